// ----- sv/rrt_pkg.sv -----
// shared types, widths and codes for the receive ring reader
package rrt_pkg;

  // fixed field widths
  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int NEED_W     = 7;
  localparam int TMO_W      = 16;
  localparam int SIZE_W     = 9;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TIMEOUT = 1'd1;

  // register reset values
  localparam logic [SIZE_W-1:0] RING_SIZE_RST = 9'd256;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 16'd10;

  // work handed from the front to the back
  typedef struct packed {
    logic              is_run;     // data burst, else a single status/fail result
    logic [SIZE_W-1:0] ptr;        // first read position
    logic [SIZE_W-1:0] size;       // ring size in effect
    logic [NEED_W-1:0] len;        // bytes in the burst
    logic              fail_flag;  // sticky flag after the step
    logic [CNT_W-1:0]  byte_count; // unread bytes after the step
  } rrt_job_t;

endpackage

// ----- sv/rrt_req_if.sv -----
// request channel: byte arrivals, ticks, reads and queries
interface rrt_req_if;
  logic                         valid;
  logic                         ready;
  logic [rrt_pkg::CMD_W-1:0]    cmd;
  logic [rrt_pkg::BYTE_W-1:0]   rx_byte;
  logic [rrt_pkg::NEED_W-1:0]   need_len;
  logic [rrt_pkg::TMO_W-1:0]    wait_ticks;
  logic                         use_default;

  modport source (output valid, cmd, rx_byte, need_len, wait_ticks, use_default,
                  input ready);
  modport sink   (input valid, cmd, rx_byte, need_len, wait_ticks, use_default,
                  output ready);
endinterface

// ----- sv/rrt_rsp_if.sv -----
// response channel: delivered bytes and status results
interface rrt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rrt_pkg::BYTE_W-1:0]  data;
  logic                        last;
  logic                        ok;
  logic                        fail_flag;
  logic [rrt_pkg::CNT_W-1:0]   byte_count;

  modport source (output valid, data, last, ok, fail_flag, byte_count, input ready);
  modport sink   (input valid, data, last, ok, fail_flag, byte_count, output ready);
endinterface

// ----- sv/rrt_cfg_if.sv -----
// configuration write channel
interface rrt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rrt_pkg::CFG_IDX_W-1:0]    index;
  logic [rrt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rrt_ram.sv -----
// generic simple dual-port ram with registered read
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rrt_front.sv -----
// front end: accepts commands, keeps ring pointers and timeout, issues jobs
module rrt_front #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_READ   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  rrt_req_if.sink                           req,
  rrt_cfg_if.sink                           cfg,
  input  logic                              quiet,
  input  logic                              q_full,
  output logic                              push,
  output rrt_pkg::rrt_job_t                 job,
  output logic                              ram_we,
  output logic [$clog2(RING_DEPTH)-1:0]     ram_waddr,
  output logic [rrt_pkg::BYTE_W-1:0]        ram_wdata
);

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int PW     = (ADDR_W > rrt_pkg::SIZE_W) ? rrt_pkg::SIZE_W : ADDR_W;
  localparam int LW     = $clog2(MAX_READ + 1);
  localparam int SW     = rrt_pkg::SIZE_W;
  localparam int NW     = rrt_pkg::NEED_W;
  localparam int TW     = rrt_pkg::TMO_W;

  // unread entries between two pointers
  function automatic logic [SW-1:0] ring_avail(input logic [SW-1:0] w,
                                               input logic [SW-1:0] r,
                                               input logic [SW-1:0] s);
    return (w >= r) ? (w - r) : (s - r + w);
  endfunction

  // state
  logic [SW-1:0] ring_size, ring_size_next;
  logic [TW-1:0] default_timeout, default_timeout_next;
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic          pending, pending_next;
  logic [LW-1:0] pending_len, pending_len_next;
  logic [TW-1:0] pending_timeout, pending_timeout_next;
  logic [TW-1:0] idle_ticks, idle_ticks_next;
  logic          failed, failed_next;

  // working values
  logic          accept;
  logic [SW-1:0] eff_size;
  logic [SW-1:0] w9, r9, w_inc;
  logic [SW-1:0] avail_now, avail_wr;
  logic [NW-1:0] need_c;
  logic [TW-1:0] tmo_sel, idle_inc;
  logic [NW-1:0] del_len;
  logic [SW-1:0] del_avail;
  logic [SW:0]   rsum;
  logic [SW-1:0] r_after;

  assign accept    = req.valid && req.ready;
  assign req.ready = !q_full && ((req.cmd != rrt_pkg::CMD_BYTE) || quiet);
  assign cfg.ready = 1'b1;

  // ring write port
  assign ram_we    = accept && (req.cmd == rrt_pkg::CMD_BYTE);
  assign ram_waddr = ADDR_W'(wr_ptr);
  assign ram_wdata = req.rx_byte;

  // effective size and pointer arithmetic
  always_comb begin
    if (ring_size == '0) begin
      eff_size = SW'(1);
    end else if (32'(ring_size) > RING_DEPTH) begin
      eff_size = SW'(RING_DEPTH);
    end else begin
      eff_size = ring_size;
    end
    w9        = SW'(wr_ptr);
    r9        = SW'(rd_ptr);
    w_inc     = ((w9 + SW'(1)) == eff_size) ? '0 : (w9 + SW'(1));
    avail_now = ring_avail(w9, r9, eff_size);
    avail_wr  = ring_avail(w_inc, r9, eff_size);
  end

  // request operands
  always_comb begin
    if (req.need_len == '0) begin
      need_c = NW'(1);
    end else if (32'(req.need_len) > MAX_READ) begin
      need_c = NW'(MAX_READ);
    end else begin
      need_c = req.need_len;
    end
    tmo_sel  = req.use_default ? default_timeout : req.wait_ticks;
    idle_inc = (idle_ticks == '1) ? idle_ticks : (idle_ticks + TW'(1));
  end

  // burst length, count and read pointer after delivery
  always_comb begin
    del_len   = (req.cmd == rrt_pkg::CMD_BYTE) ? NW'(pending_len) : need_c;
    del_avail = (req.cmd == rrt_pkg::CMD_BYTE) ? avail_wr : avail_now;
    rsum      = {1'b0, r9} + (SW + 1)'(del_len);
    r_after   = (rsum >= {1'b0, eff_size}) ? SW'(rsum - {1'b0, eff_size}) : SW'(rsum);
  end

  // command decode and next state
  always_comb begin
    ring_size_next       = ring_size;
    default_timeout_next = default_timeout;
    wr_ptr_next          = wr_ptr;
    rd_ptr_next          = rd_ptr;
    pending_next         = pending;
    pending_len_next     = pending_len;
    pending_timeout_next = pending_timeout;
    idle_ticks_next      = idle_ticks;
    failed_next          = failed;
    push                 = 1'b0;
    job.is_run           = 1'b0;
    job.ptr              = r9;
    job.size             = eff_size;
    job.len              = del_len;
    job.fail_flag        = failed;
    job.byte_count       = avail_now[rrt_pkg::CNT_W-1:0];

    if (accept) begin
      unique case (req.cmd)
        rrt_pkg::CMD_BYTE: begin
          wr_ptr_next     = PW'(w_inc);
          idle_ticks_next = '0;
          if (pending && (avail_wr >= SW'(pending_len))) begin
            push           = 1'b1;
            job.is_run     = 1'b1;
            job.byte_count = rrt_pkg::CNT_W'(del_avail - SW'(del_len));
            rd_ptr_next    = PW'(r_after);
            pending_next   = 1'b0;
          end
        end
        rrt_pkg::CMD_TICK: begin
          if (pending) begin
            idle_ticks_next = idle_inc;
            if (idle_inc >= pending_timeout) begin
              // timed out: drop unread bytes unless the timeout is zero
              if (pending_timeout != '0) begin
                rd_ptr_next    = wr_ptr;
                job.byte_count = '0;
              end
              failed_next   = 1'b1;
              pending_next  = 1'b0;
              push          = 1'b1;
              job.fail_flag = 1'b1;
            end
          end
        end
        rrt_pkg::CMD_READ: begin
          pending_next = 1'b0;
          if (avail_now >= SW'(need_c)) begin
            push           = 1'b1;
            job.is_run     = 1'b1;
            job.byte_count = rrt_pkg::CNT_W'(del_avail - SW'(del_len));
            rd_ptr_next    = PW'(r_after);
          end else if (tmo_sel == '0) begin
            failed_next   = 1'b1;
            push          = 1'b1;
            job.fail_flag = 1'b1;
          end else begin
            pending_next         = 1'b1;
            pending_len_next     = LW'(need_c);
            pending_timeout_next = tmo_sel;
            idle_ticks_next      = '0;
          end
        end
        rrt_pkg::CMD_CLEAR: begin
          failed_next = 1'b0;
        end
        rrt_pkg::CMD_STATUS: begin
          push = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // register writes
    if (cfg.valid) begin
      unique case (cfg.index)
        rrt_pkg::REG_RING_SIZE: begin
          ring_size_next = cfg.data[SW-1:0];
          wr_ptr_next    = '0;
          rd_ptr_next    = '0;
        end
        rrt_pkg::REG_DEFAULT_TIMEOUT: begin
          default_timeout_next = cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size       <= rrt_pkg::RING_SIZE_RST;
      default_timeout <= rrt_pkg::TIMEOUT_RST;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      pending         <= 1'b0;
      pending_len     <= '0;
      pending_timeout <= '0;
      idle_ticks      <= '0;
      failed          <= 1'b0;
    end else begin
      ring_size       <= ring_size_next;
      default_timeout <= default_timeout_next;
      wr_ptr          <= wr_ptr_next;
      rd_ptr          <= rd_ptr_next;
      pending         <= pending_next;
      pending_len     <= pending_len_next;
      pending_timeout <= pending_timeout_next;
      idle_ticks      <= idle_ticks_next;
      failed          <= failed_next;
    end
  end

endmodule

// ----- sv/rrt_queue.sv -----
// short job queue between front and back
module rrt_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrt_pkg::rrt_job_t push_job,
  input  logic              pop,
  output rrt_pkg::rrt_job_t head,
  output logic              full,
  output logic              empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rrt_pkg::rrt_job_t slots [DEPTH];
  logic [IW-1:0] wr_idx, rd_idx;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_idx];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == IW'(DEPTH - 1)) ? '0 : (wr_idx + IW'(1));
      end
      if (pop) begin
        rd_idx <= (rd_idx == IW'(DEPTH - 1)) ? '0 : (rd_idx + IW'(1));
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- sv/rrt_back.sv -----
// back end: plays out jobs, reading burst bytes from the ring
module rrt_back #(
  parameter int ADDR_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  rrt_pkg::rrt_job_t           q_head,
  output logic                        pop,
  output logic                        busy,
  output logic                        ram_re,
  output logic [ADDR_W-1:0]           ram_raddr,
  input  logic [rrt_pkg::BYTE_W-1:0]  ram_rdata,
  rrt_rsp_if.source                   rsp
);

  localparam int SW = rrt_pkg::SIZE_W;
  localparam int NW = rrt_pkg::NEED_W;

  rrt_pkg::rrt_job_t cur;
  logic [SW-1:0] ptr, ptr_inc;
  logic [NW-1:0] remain;
  logic          advance;
  logic          out_valid, out_is_data, out_last, out_ok, out_fail;
  logic [rrt_pkg::CNT_W-1:0] out_count;

  // output register frees up when empty or taken
  assign advance   = !out_valid || rsp.ready;
  assign pop       = !busy && !q_empty;
  assign ptr_inc   = ((ptr + SW'(1)) == cur.size) ? '0 : (ptr + SW'(1));
  assign ram_re    = busy && advance && cur.is_run;
  assign ram_raddr = ADDR_W'(ptr);

  // response port
  assign rsp.valid      = out_valid;
  assign rsp.data       = out_is_data ? ram_rdata : '0;
  assign rsp.last       = out_last;
  assign rsp.ok         = out_ok;
  assign rsp.fail_flag  = out_fail;
  assign rsp.byte_count = out_count;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && advance && (remain == NW'(1))) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= busy;
      end
    end
  end

  // job load and per-result step
  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= q_head;
      ptr    <= q_head.ptr;
      remain <= q_head.is_run ? q_head.len : NW'(1);
    end else if (busy && advance) begin
      ptr    <= ptr_inc;
      remain <= remain - NW'(1);
    end
    if (busy && advance) begin
      out_is_data <= cur.is_run;
      out_last    <= (remain == NW'(1));
      out_ok      <= cur.is_run;
      out_fail    <= cur.fail_flag;
      out_count   <= cur.byte_count;
    end
  end

endmodule

// ----- sv/rx_ring_reader_with_timeout.sv -----
// top level: receive ring reader with idle timeout
//
//   channel  dir  handshake     carries
//   req      in   valid/ready   cmd, rx_byte, need_len, wait_ticks, use_default
//   rsp      out  valid/ready   data, last, ok, fail_flag, byte_count
//   cfg      in   valid/ready   index, data (0 ring_size, 1 default_timeout)
//
// ticks, reads, clears and queries are taken one per cycle while the job queue has room.
// a read burst streams one byte per cycle from the ring ram while rsp is ready;
// before its first byte, the job passes the queue, the back end load and the ram read.
// a byte arrival is held off while any job still waits in the queue or the back end.
// reset is synchronous; the ring store itself is not cleared.
// a stall on rsp holds the back end; the queue keeps the front end going until it fills.
module rx_ring_reader_with_timeout #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_READ   = 64
) (
  input  logic       clk,
  input  logic       rst,
  rrt_req_if.sink    req,
  rrt_rsp_if.source  rsp,
  rrt_cfg_if.sink    cfg
);

  localparam int ADDR_W = $clog2(RING_DEPTH);

  rrt_pkg::rrt_job_t push_job, q_head;
  logic push, pop, q_full, q_empty, back_busy, quiet;
  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [rrt_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  // no burst in flight
  assign quiet = q_empty && !back_busy;

  rrt_front #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .quiet     (quiet),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  rrt_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rrt_ram #(
    .WIDTH (rrt_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrt_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .busy      (back_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rsp       (rsp)
  );

endmodule
